// ===== hw/rtl/csps_pkg.sv =====
`default_nettype none

package csps_pkg;

    // Fixed-point fraction of the surface math: one unit is 1/8192.
    localparam int FRAC_BITS = 13;

    // Width of an arcsine argument, after the 11/8 prescale.
    localparam int ARC_W = 18;

    // Register stages inside the arcsine unit.
    localparam int ARC_STAGES = 9;

    // Surface coordinates wrap to this many bits.
    localparam int WRAP_W = 13;

    // Width of a band weight, 0 to 256.
    localparam int BAND_W = 9;

    // Tilt rotation coefficients, cos and sin in units of 1/8192.
    localparam logic signed [14:0] COS_TILT = 15'sd8028;
    localparam logic signed [14:0] SIN_TILT = 15'sd1627;

    // Arcsine polynomial coefficients.
    localparam logic signed [11:0] ARC_CUBIC = 12'sd1365;
    localparam logic signed [10:0] ARC_QUINT = 11'sd614;

    // Horizontal width table, 33 knots over the vertical radius.
    function automatic logic [15:0] width_tab(input logic [5:0] idx);
        logic [15:0] val;
        case (idx)
            6'd0:    val = 16'd8192;
            6'd1:    val = 16'd8196;
            6'd2:    val = 16'd8208;
            6'd3:    val = 16'd8228;
            6'd4:    val = 16'd8256;
            6'd5:    val = 16'd8293;
            6'd6:    val = 16'd8339;
            6'd7:    val = 16'd8395;
            6'd8:    val = 16'd8460;
            6'd9:    val = 16'd8536;
            6'd10:   val = 16'd8623;
            6'd11:   val = 16'd8723;
            6'd12:   val = 16'd8836;
            6'd13:   val = 16'd8965;
            6'd14:   val = 16'd9110;
            6'd15:   val = 16'd9273;
            6'd16:   val = 16'd9459;
            6'd17:   val = 16'd9669;
            6'd18:   val = 16'd9908;
            6'd19:   val = 16'd10180;
            6'd20:   val = 16'd10494;
            6'd21:   val = 16'd10856;
            6'd22:   val = 16'd11280;
            6'd23:   val = 16'd11782;
            6'd24:   val = 16'd12385;
            6'd25:   val = 16'd13123;
            6'd26:   val = 16'd14052;
            6'd27:   val = 16'd15262;
            6'd28:   val = 16'd16921;
            6'd29:   val = 16'd19378;
            6'd30:   val = 16'd23541;
            6'd31:   val = 16'd33027;
            6'd32:   val = 16'd65535;
            default: val = 16'd65535;
        endcase
        return val;
    endfunction

    // Edge weight: ramps down over the first 256 units, zero in the middle,
    // ramps up again past the half point, and full beyond that.
    function automatic logic [BAND_W-1:0] band(input logic [WRAP_W-1:0] v);
        logic [BAND_W-1:0] res;
        if (v < 13'd256) begin
            res = BAND_W'(13'd256 - v);
        end else if (v < 13'd4096) begin
            res = '0;
        end else if (v < 13'd4352) begin
            res = BAND_W'(v - 13'd4096);
        end else begin
            res = 9'd256;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/csps_arcsin.sv =====
`default_nettype none

// Nine-stage arcsine approximation v + (1365*v^3 + 614*v^5) / 8192 in
// the 1/8192 fixed-point scale, with every division truncated toward zero.
// Only the wrapped low bits of the result leave the unit.
module csps_arcsin (
    input  logic                                    aclk,
    input  logic [csps_pkg::ARC_STAGES-1:0]         stage_en,
    input  logic signed [csps_pkg::ARC_W-1:0]       v_in,
    output logic [csps_pkg::WRAP_W-1:0]             res_out
);

    localparam int AW = csps_pkg::ARC_W;
    localparam int FB = csps_pkg::FRAC_BITS;
    localparam int WW = csps_pkg::WRAP_W;

    logic signed [AW-1:0] v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;

    logic signed [35:0] sqp_reg, sqp_next;
    logic [20:0]        sq2_reg, sq3_reg, sq4_reg, sq_next;
    logic signed [39:0] cup_reg, cup_next, cu_bias;
    logic signed [25:0] cu4_reg, cu_next;
    logic signed [47:0] qup_reg, qup_next, qu_bias;
    logic signed [37:0] m1_full;
    logic signed [36:0] m1_5_reg, m1_6_reg, m1_7_reg, m1_next;
    logic signed [32:0] qu6_reg, qu_next;
    logic signed [43:0] m2_full;
    logic signed [42:0] m2_reg, m2_next;
    logic signed [43:0] s_reg, s_next, s_bias;
    logic [WW-1:0]      res_reg, res_next;

    assign sqp_next = v_in * v_in;
    // The square is never negative, so a plain shift divides it.
    assign sq_next  = sqp_reg[33:FB];
    assign cup_next = $signed({1'b0, sq2_reg}) * v2_reg;
    assign cu_bias  = cup_reg + (cup_reg[39] ? 40'sd8191 : 40'sd0);
    assign cu_next  = cu_bias[38:FB];
    assign qup_next = $signed({1'b0, sq4_reg}) * cu4_reg;
    assign m1_full  = cu4_reg * csps_pkg::ARC_CUBIC;
    assign m1_next  = m1_full[36:0];
    assign qu_bias  = qup_reg + (qup_reg[47] ? 48'sd8191 : 48'sd0);
    assign qu_next  = qu_bias[45:FB];
    assign m2_full  = qu6_reg * csps_pkg::ARC_QUINT;
    assign m2_next  = m2_full[42:0];
    assign s_next   = m2_reg + m1_7_reg;
    assign s_bias   = s_reg + (s_reg[43] ? 44'sd8191 : 44'sd0);
    assign res_next = v8_reg[WW-1:0] + s_bias[FB+WW-1:FB];

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            sqp_reg <= sqp_next;
            v1_reg  <= v_in;
        end
        if (stage_en[1]) begin
            sq2_reg <= sq_next;
            v2_reg  <= v1_reg;
        end
        if (stage_en[2]) begin
            cup_reg <= cup_next;
            sq3_reg <= sq2_reg;
            v3_reg  <= v2_reg;
        end
        if (stage_en[3]) begin
            cu4_reg <= cu_next;
            sq4_reg <= sq3_reg;
            v4_reg  <= v3_reg;
        end
        if (stage_en[4]) begin
            qup_reg  <= qup_next;
            m1_5_reg <= m1_next;
            v5_reg   <= v4_reg;
        end
        if (stage_en[5]) begin
            qu6_reg  <= qu_next;
            m1_6_reg <= m1_5_reg;
            v6_reg   <= v5_reg;
        end
        if (stage_en[6]) begin
            m2_reg   <= m2_next;
            m1_7_reg <= m1_6_reg;
            v7_reg   <= v6_reg;
        end
        if (stage_en[7]) begin
            s_reg  <= s_next;
            v8_reg <= v7_reg;
        end
        if (stage_en[8]) begin
            res_reg <= res_next;
        end
    end

    assign res_out = res_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/checkered_sphere_pixel_shader_core.sv =====
`default_nettype none

// Per-pixel shader for a spinning checkered ball.
// Input channel (s_*): one item per pixel carrying the screen x, screen y
// and the spin phase. Result channel (m_*): one item per input item, in
// order, with the inside flag on m_tuser and the RGB565 color on m_tdata.
// Pixels beyond the ball radius come out with the flag low and color zero.
// The block is a 21-stage pipeline. With m_tready held high it takes
// and delivers one item every cycle. The longest stage holds one
// multiplier of up to 22 by 26 bits in the arcsine unit, or one wide
// add with a shift.
// When the receiver stalls, each stage still fills while it or any stage after
// it is empty, so s_tready drops only once every stage holds an item;
// nothing is lost or repeated. Reset (aresetn low, synchronous) empties
// the pipeline; the block keeps no other state.
module checkered_sphere_pixel_shader_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // pixel_x [14:0], pixel_y [29:15], phase [42:30], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // color [15:0]
    output logic [0:0]  m_tuser    // inside_res [0]
);

    localparam int NUM_STAGES = 21;
    localparam int SIDE_FIRST = 4;
    localparam int SIDE_LEN   = 16;
    localparam int ARC_FIRST  = 7;
    localparam int BAND_STAGE = ARC_FIRST + csps_pkg::ARC_STAGES;
    localparam int FB         = csps_pkg::FRAC_BITS;
    localparam int AW         = csps_pkg::ARC_W;
    localparam int WW         = csps_pkg::WRAP_W;
    localparam int BW         = csps_pkg::BAND_W;

    typedef struct packed {
        logic          in_ball;
        logic [BW-1:0] shade;
        logic [WW-1:0] phase;
    } side_t;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] stage_en;

    // A stage may load when some stage at or after it is empty, or when
    // the receiver takes the output.
    always_comb begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            stage_en[k] = m_tready ||
                !(&(valid_reg | ((NUM_STAGES'(1) << k) - NUM_STAGES'(1))));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_en[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (stage_en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[NUM_STAGES-1];

    // Stage 0: halve and center, then the four rotation products.
    logic signed [14:0] sx, sy;
    logic signed [27:0] pxx_next, pxy_next, pyx_next, pyy_next;
    logic signed [27:0] pxx_reg, pxy_reg, pyx_reg, pyy_reg;
    logic [WW-1:0]      ph0_reg, ph1_reg, ph2_reg, ph3_reg;

    assign sx = $signed({1'b0, s_tdata[14:1]}) - 15'sd8192;
    assign sy = $signed({1'b0, s_tdata[29:16]}) - 15'sd8192;
    assign pxx_next = sx * csps_pkg::COS_TILT;
    assign pxy_next = sy * csps_pkg::SIN_TILT;
    assign pyx_next = sx * csps_pkg::SIN_TILT;
    assign pyy_next = sy * csps_pkg::COS_TILT;

    // Stage 1: rotated coordinates, divided toward zero.
    logic signed [27:0] xsum, ysum, xbias, ybias;
    logic signed [14:0] x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg;

    assign xsum  = pxx_reg + pxy_reg;
    assign ysum  = pyy_reg - pyx_reg;
    assign xbias = xsum + (xsum[27] ? 28'sd8191 : 28'sd0);
    assign ybias = ysum + (ysum[27] ? 28'sd8191 : 28'sd0);

    // Stage 2: squares and the two width table products.
    logic signed [29:0] xsq_full, ysq_full;
    logic [26:0]        xsq_reg, ysq_reg;
    logic [14:0]        yabs;
    logic [12:0]        ysat;
    logic [4:0]         seg;
    logic [7:0]         frac;
    logic [15:0]        knot_a, knot_b;
    logic [23:0]        pa_next, pb_next, pa_reg, pb_reg;

    assign xsq_full = x1_reg * x1_reg;
    assign ysq_full = y1_reg * y1_reg;
    assign yabs     = y1_reg[14] ? 15'(-y1_reg) : 15'(y1_reg);
    assign ysat     = (yabs > 15'd8191) ? 13'd8191 : yabs[12:0];
    assign seg      = ysat[12:8];
    assign frac     = ysat[7:0];
    assign knot_a   = csps_pkg::width_tab({1'b0, seg});
    assign knot_b   = csps_pkg::width_tab(6'({1'b0, seg}) + 6'd1);
    assign pa_next  = knot_a * (8'hff - frac);
    assign pb_next  = knot_b * frac;

    // Stage 3: squared radius and interpolated width.
    logic [27:0] r_next, r_reg;
    logic [23:0] wsum;
    logic [15:0] wc_reg;

    assign r_next = {1'b0, xsq_reg} + {1'b0, ysq_reg};
    assign wsum   = pa_reg + pb_reg;

    // Stage 4: widened x product, prescaled y, inside test and rim shade.
    logic signed [31:0] xwp_next, xwp_reg;
    logic signed [18:0] y11, y11_bias;
    logic signed [AW-1:0] yv_next, yv5_reg, yv6_reg, yv7_reg, xv_reg;
    logic [12:0]        rs, bv;
    side_t              side_in;
    side_t              side_reg [SIDE_LEN];

    assign xwp_next = x3_reg * $signed({1'b0, wc_reg});
    assign y11      = y3_reg * 5'sd11;
    assign y11_bias = y11 + (y11[18] ? 19'sd7 : 19'sd0);
    assign yv_next  = {{2{y11_bias[18]}}, y11_bias[18:3]};
    assign side_in.in_ball = (r_reg <= 28'd67108864);
    assign rs       = side_in.in_ball ? r_reg[26:14] : 13'd4096;
    assign bv       = 13'd4096 - rs;
    assign side_in.shade = 9'd256 - csps_pkg::band(bv);
    assign side_in.phase = ph3_reg;

    // Stage 5: widened x divided toward zero.
    logic signed [31:0] xwp_bias;
    logic signed [17:0] xw_reg;

    assign xwp_bias = xwp_reg + (xwp_reg[31] ? 32'sd8191 : 32'sd0);

    // Stage 6: prescaled x.
    logic signed [21:0] x11, x11_bias;

    assign x11      = xw_reg * 5'sd11;
    assign x11_bias = x11 + (x11[21] ? 22'sd7 : 22'sd0);

    // Stages 7 to 15: both arcsine units.
    logic [WW-1:0] ax, ay;

    csps_arcsin u_arcsin_x (
        .aclk     (aclk),
        .stage_en (stage_en[ARC_FIRST +: csps_pkg::ARC_STAGES]),
        .v_in     (xv_reg),
        .res_out  (ax)
    );

    csps_arcsin u_arcsin_y (
        .aclk     (aclk),
        .stage_en (stage_en[ARC_FIRST +: csps_pkg::ARC_STAGES]),
        .v_in     (yv7_reg),
        .res_out  (ay)
    );

    // Stage 16: spin and checker bands.
    side_t         side_band;
    logic [WW-1:0] xs;
    logic [BW-1:0] cx_reg, cy_reg;

    assign side_band = side_reg[BAND_STAGE - 1 - SIDE_FIRST];
    assign xs        = ax + side_band.phase;

    // Stage 17: checker product.
    logic signed [9:0]  dx, dy;
    logic signed [19:0] prod_next, prod_reg, prod_bias;

    assign dx        = $signed({1'b0, cx_reg}) - 10'sd128;
    assign dy        = $signed({1'b0, cy_reg}) - 10'sd128;
    assign prod_next = dx * dy;

    // Stage 18: checker blend.
    logic signed [12:0] cc_sum;
    logic [BW-1:0]      cc_reg;

    assign prod_bias = prod_reg + (prod_reg[19] ? 20'sd127 : 20'sd0);
    assign cc_sum    = prod_bias[19:7] + 13'sd128;

    // Stage 19: green and blue before shading.
    logic [14:0] g_full;
    logic [13:0] b_full;
    logic [5:0]  grn_reg;
    logic [4:0]  blu_reg;

    assign g_full = cc_reg * 6'd63;
    assign b_full = cc_reg * 5'd31;

    // Stage 20: rim shading and packing.
    side_t       side_out;
    logic [13:0] r_shade, b_shade;
    logic [14:0] g_shade;
    logic [15:0] color_next, color_reg;
    logic        inside_reg;

    assign side_out   = side_reg[SIDE_LEN-1];
    assign r_shade    = 5'd31 * side_out.shade;
    assign g_shade    = grn_reg * side_out.shade;
    assign b_shade    = blu_reg * side_out.shade;
    assign color_next = side_out.in_ball ?
                        {r_shade[12:8], g_shade[13:8], b_shade[12:8]} : 16'd0;

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            pxx_reg <= pxx_next;
            pxy_reg <= pxy_next;
            pyx_reg <= pyx_next;
            pyy_reg <= pyy_next;
            ph0_reg <= s_tdata[42:30];
        end
        if (stage_en[1]) begin
            x1_reg  <= xbias[27:FB];
            y1_reg  <= ybias[27:FB];
            ph1_reg <= ph0_reg;
        end
        if (stage_en[2]) begin
            xsq_reg <= xsq_full[26:0];
            ysq_reg <= ysq_full[26:0];
            pa_reg  <= pa_next;
            pb_reg  <= pb_next;
            x2_reg  <= x1_reg;
            y2_reg  <= y1_reg;
            ph2_reg <= ph1_reg;
        end
        if (stage_en[3]) begin
            r_reg   <= r_next;
            wc_reg  <= wsum[23:8];
            x3_reg  <= x2_reg;
            y3_reg  <= y2_reg;
            ph3_reg <= ph2_reg;
        end
        if (stage_en[SIDE_FIRST]) begin
            xwp_reg    <= xwp_next;
            yv5_reg    <= yv_next;
            side_reg[0] <= side_in;
        end
        for (int i = 1; i < SIDE_LEN; i++) begin
            if (stage_en[SIDE_FIRST + i]) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
        if (stage_en[5]) begin
            xw_reg  <= xwp_bias[30:FB];
            yv6_reg <= yv5_reg;
        end
        if (stage_en[6]) begin
            xv_reg  <= x11_bias[20:3];
            yv7_reg <= yv6_reg;
        end
        if (stage_en[BAND_STAGE]) begin
            cx_reg <= csps_pkg::band(xs);
            cy_reg <= csps_pkg::band(ay);
        end
        if (stage_en[BAND_STAGE + 1]) begin
            prod_reg <= prod_next;
        end
        if (stage_en[BAND_STAGE + 2]) begin
            cc_reg <= cc_sum[8:0];
        end
        if (stage_en[BAND_STAGE + 3]) begin
            grn_reg <= g_full[13:8];
            blu_reg <= b_full[12:8];
        end
        if (stage_en[NUM_STAGES-1]) begin
            color_reg  <= color_next;
            inside_reg <= side_out.in_ball;
        end
    end

    assign m_tdata = color_reg;
    assign m_tuser = inside_reg;

    // A pixel outside the ball never carries a color.
    a_outside_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 16'd0)
        else $error("outside pixel with nonzero color");

    // With the output stage empty the whole pipeline can move.
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg[NUM_STAGES-1] |-> s_tready)
        else $error("input stalled while the output stage is empty");

    // An accepted item lands in the first stage.
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> valid_reg[0])
        else $error("accepted item did not enter the pipeline");

    // A held item in front of the arcsine units is never dropped.
    a_hold_arc_input: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[ARC_FIRST-1] && !stage_en[ARC_FIRST] |=> valid_reg[ARC_FIRST-1])
        else $error("stalled item lost before the arcsine units");

endmodule

`default_nettype wire

// ===== sim/pixel_shade_checker.sv =====
module pixel_shade_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // pixel_x [14:0], pixel_y [29:15], phase [42:30], zero
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // color [15:0]
    input  logic [0:0]  m_tuser,   // inside_res [0]
    output int          fail_count,
    output int          pending_count
);

    typedef struct {
        logic        inside_res;
        logic [15:0] color;
    } pixel_result_t;

    pixel_result_t pending_pixels[$];
    int errs = 0;

    // Horizontal widening over the vertical radius, 33 knots 256 units apart.
    longint width_knots [0:32] = '{
        8192,  8196,  8208,  8228,  8256,  8293,  8339,  8395,  8460,  8536,
        8623,  8723,  8836,  8965,  9110,  9273,  9459,  9669,  9908,  10180,
        10494, 10856, 11280, 11782, 12385, 13123, 14052, 15262, 16921, 19378,
        23541, 33027, 65535
    };

    function automatic longint width_gain(input longint yv);
        longint v, seg, fr, a, b;
        v = (yv < 0) ? -yv : yv;
        if (v > 8191) v = 8191;
        seg = v / 256;
        fr = v & 255;
        a = width_knots[seg & 31];
        b = width_knots[(seg & 31) + 1];
        return (a * (255 - fr) + b * fr) / 256;
    endfunction

    function automatic longint asin_approx(input longint arg);
        longint v, sq, cu, qu;
        v = (arg * 11) / 8;
        sq = (v * v) / 8192;
        cu = (sq * v) / 8192;
        qu = (sq * cu) / 8192;
        return v + (1365 * cu + 614 * qu) / 8192;
    endfunction

    function automatic longint stripe_weight(input longint v);
        if (v < 256) return 256 - v;
        if (v < 4096) return 0;
        if (v < 4352) return v - 4096;
        return 256;
    endfunction

    function automatic void shade_pixel(input logic [14:0] px, input logic [14:0] py,
                                        input logic [12:0] ph, output pixel_result_t res);
        longint sx, sy, phs, x, y, r, cx, cy, cc, red, grn, blu, shade;
        sx = px;
        sy = py;
        phs = ph;
        sx = sx / 2 - 8192;
        sy = sy / 2 - 8192;
        x = (8028 * sx + 1627 * sy) / 8192;
        y = (-1627 * sx + 8028 * sy) / 8192;
        r = x * x + y * y;
        if (r > 67108864) begin
            res.inside_res = 1'b0;
            res.color = '0;
            return;
        end
        x = (x * width_gain(y)) / 8192;
        y = asin_approx(y);
        x = asin_approx(x) + phs;
        // Two's complement wrap keeps the low 13 bits of negative coordinates.
        x = x & 64'h1fff;
        y = y & 64'h1fff;
        cx = stripe_weight(x);
        cy = stripe_weight(y);
        cc = ((cx - 128) * (cy - 128)) / 128 + 128;
        red = 31;
        grn = (63 * cc) / 256;
        blu = (31 * cc) / 256;
        shade = 256 - stripe_weight(4096 - r / 16384);
        red = (red * shade) / 256;
        grn = (grn * shade) / 256;
        blu = (blu * shade) / 256;
        res.inside_res = 1'b1;
        res.color = 16'((red << 11) + (grn << 5) + blu);
    endfunction

    always @(posedge aclk) begin
        pixel_result_t want;
        pixel_result_t got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_pixels.size() == 0) begin
                    $error("result item with no pixel pending: inside_res=%0d color=%h",
                           m_tuser[0], m_tdata);
                    errs++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (m_tuser[0] !== want.inside_res) begin
                        $error("inside_res mismatch: expected %0d, actual %0d",
                               want.inside_res, m_tuser[0]);
                        errs++;
                    end
                    if (m_tdata !== want.color) begin
                        $error("color mismatch: expected %h, actual %h", want.color, m_tdata);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                shade_pixel(s_tdata[14:0], s_tdata[29:15], s_tdata[42:30], got);
                pending_pixels.push_back(got);
            end
        end
        fail_count <= errs;
        pending_count <= pending_pixels.size();
    end

endmodule

// ===== sim/checkered_sphere_pixel_shader_core_test.sv =====
module checkered_sphere_pixel_shader_core_test;

    logic        aclk = 1'b1;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // pixel_x [14:0], pixel_y [29:15], phase [42:30], zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // color [15:0]
    logic [0:0]  m_tuser;        // inside_res [0]
    int          fail_count;
    int          pending_count;
    int          send_run = 0;
    int          take_run = 0;

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    checkered_sphere_pixel_shader_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    pixel_shade_checker watch (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Mostly random waits, with occasional runs of back-to-back items.
    function automatic int draw_gap(inout int run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            run_left = $urandom_range(16, 64);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic feed_pixel(input logic [14:0] px, input logic [14:0] py,
                              input logic [12:0] ph);
        int gap;
        gap = draw_gap(send_run);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, ph, py, px};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    function automatic logic [14:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 15'd0;
            1: return 15'd32767;
            2: return 15'($urandom_range(0, 3));
            3: return 15'($urandom_range(32764, 32767));
            default: return 15'($urandom_range(0, 32767));
        endcase
    endfunction

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Corners, center, and the axis points of the screen.
        feed_pixel(15'd0, 15'd0, 13'd0);
        feed_pixel(15'd32767, 15'd32767, 13'd8191);
        feed_pixel(15'd16384, 15'd16384, 13'd0);
        feed_pixel(15'd16385, 15'd16385, 13'd8191);
        feed_pixel(15'd16384, 15'd0, 13'd0);
        feed_pixel(15'd0, 15'd16384, 13'd4096);
        feed_pixel(15'd32767, 15'd16384, 13'd1);
        feed_pixel(15'd16384, 15'd32767, 13'd2);
        feed_pixel(15'd0, 15'd32767, 13'd100);
        feed_pixel(15'd32767, 15'd0, 13'd7000);
        // The rotated y reaches +8192 and -8192 on the rim, so the width
        // table index saturates; two sit exactly at the radius limit, one just past it.
        feed_pixel(15'd13128, 15'd32444, 13'd0);
        feed_pixel(15'd19640, 15'd324, 13'd8191);
        feed_pixel(15'd13128, 15'd32446, 13'd0);
        // Negative surface coordinates in either axis.
        feed_pixel(15'd12000, 15'd16000, 13'd0);
        feed_pixel(15'd20000, 15'd12000, 13'd0);
        feed_pixel(15'd17000, 15'd17000, 13'd4095);
        feed_pixel(15'd16000, 15'd17500, 13'd4096);
        feed_pixel(15'd24000, 15'd9000, 13'h1555);
        feed_pixel(15'd9000, 15'd24000, 13'h0aaa);
        feed_pixel(15'd16500, 15'd16300, 13'd256);

        repeat (1500) begin
            feed_pixel(pick_coord(), pick_coord(), 13'($urandom_range(0, 8191)));
        end
        s_tvalid <= 1'b0;

        while (pending_count != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("[checkered_sphere_pixel_shader_core] OK");
        end else begin
            $display("[checkered_sphere_pixel_shader_core] ERROR");
        end
        $finish;
    end

    // Receiver: drops m_tready for a random gap, or none, before taking each result item.
    initial begin
        int gap;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            gap = draw_gap(take_run);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    initial begin
        #2000000;
        $display("[checkered_sphere_pixel_shader_core] ERROR");
        $finish;
    end

endmodule
